### rtl/ihex_pkg.sv
`default_nettype none

package ihex_pkg;

    // Line status codes carried on a status result.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_START = 3'd2,
        ST_CHECKSUM  = 3'd3,
        ST_MALFORMED = 3'd4
    } t_line_status;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Error flag bits collected while a line streams in.
    localparam int FLAG_START = 0;
    localparam int FLAG_HEX   = 1;
    localparam int FLAG_OVER  = 2;

    localparam logic [7:0] START_CHAR     = 8'h3A;
    localparam logic [7:0] MIN_LINE_CHARS = 8'd10;
    localparam logic [7:0] IDX_COUNT      = 8'd0;
    localparam logic [7:0] IDX_ADDR_HI    = 8'd1;
    localparam logic [7:0] IDX_ADDR_LO    = 8'd2;
    localparam logic [7:0] IDX_TYPE       = 8'd3;
    localparam logic [7:0] IDX_DATA       = 8'd4;
    localparam logic [7:0] TYPE_DATA      = 8'd0;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        logic         result_kind;
        logic [15:0]  write_address;
        logic [7:0]   write_data;
        t_line_status line_status;
        logic         last_of_line;
    } t_out_item;

    // One finished line, handed from the decoder to the drain side.
    typedef struct packed {
        t_line_status status;
        logic         do_writes;
        logic [7:0]   count;
        logic [15:0]  address;
    } t_line_job;

    // Returns {valid, nibble} for one ASCII hex digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/ihex_front.sv
`default_nettype none

module ihex_front #(
    parameter int MAX_RECORD_BYTES = 32,
    parameter int MAX_LINE_CHARS   = 254,
    parameter int IW               = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire ihex_pkg::t_in_item i_item,
    output logic                   o_wr_en,
    output logic [IW-1:0]          o_wr_index,
    output logic [7:0]             o_wr_data,
    output logic                   o_push,
    output ihex_pkg::t_line_job    o_job
);
    import ihex_pkg::*;

    localparam logic [7:0] LINE_MAX = 8'(MAX_LINE_CHARS);
    localparam logic [7:0] REC_MAX  = 8'(MAX_RECORD_BYTES);

    logic [7:0]  r_char_count, n_char_count;
    logic [3:0]  r_pending, n_pending;
    logic [7:0]  r_byte_sum, n_byte_sum;
    logic [7:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_record_count, n_record_count;
    logic [15:0] r_record_address, n_record_address;
    logic [7:0]  r_record_type, n_record_type;
    logic [2:0]  r_flags, n_flags;

    logic [4:0]  hex;
    logic [7:0]  byte_val;
    logic [7:0]  data_off;
    logic        malformed;

    assign hex      = hex_decode(i_item.text_char);
    assign byte_val = {r_pending, hex[3:0]};
    assign data_off = r_byte_index - IDX_DATA;

    assign malformed = r_flags[FLAG_HEX] || r_flags[FLAG_OVER] || !r_char_count[0]
                    || (r_record_count > REC_MAX)
                    || ({1'b0, r_byte_index} != ({1'b0, r_record_count} + 9'd5));

    always_comb begin
        n_char_count     = r_char_count;
        n_pending        = r_pending;
        n_byte_sum       = r_byte_sum;
        n_byte_index     = r_byte_index;
        n_record_count   = r_record_count;
        n_record_address = r_record_address;
        n_record_type    = r_record_type;
        n_flags          = r_flags;
        o_wr_en          = 1'b0;
        o_wr_index       = data_off[IW-1:0];
        o_wr_data        = byte_val;
        o_push           = 1'b0;
        o_job.status     = ST_OK;
        o_job.do_writes  = 1'b0;
        o_job.count      = r_record_count;
        o_job.address    = r_record_address;

        if (r_char_count == 8'd0) begin
            o_job.status = ST_OK;
        end else if (r_char_count < MIN_LINE_CHARS) begin
            o_job.status = ST_SHORT;
        end else if (r_flags[FLAG_START]) begin
            o_job.status = ST_BAD_START;
        end else if (malformed) begin
            o_job.status = ST_MALFORMED;
        end else if (r_byte_sum != 8'd0) begin
            o_job.status = ST_CHECKSUM;
        end
        o_job.do_writes = (r_char_count != 8'd0) && (o_job.status == ST_OK)
                       && (r_record_type == TYPE_DATA);

        if (i_accept && i_item.end_of_line) begin
            o_push           = 1'b1;
            n_char_count     = 8'd0;
            n_pending        = 4'd0;
            n_byte_sum       = 8'd0;
            n_byte_index     = 8'd0;
            n_record_count   = 8'd0;
            n_record_address = 16'd0;
            n_record_type    = 8'd0;
            n_flags          = 3'd0;
        end else if (i_accept) begin
            if (r_char_count >= LINE_MAX) begin
                n_flags[FLAG_OVER] = 1'b1;
            end else begin
                n_char_count = r_char_count + 8'd1;
                if (r_char_count == 8'd0) begin
                    if (i_item.text_char != START_CHAR) begin
                        n_flags[FLAG_START] = 1'b1;
                    end
                end else begin
                    if (!hex[4]) begin
                        n_flags[FLAG_HEX] = 1'b1;
                    end
                    if (r_char_count[0]) begin
                        n_pending = hex[3:0];
                    end else begin
                        // Second digit of a pair completes a byte.
                        n_byte_sum = r_byte_sum + byte_val;
                        if (r_byte_index != 8'hFF) begin
                            n_byte_index = r_byte_index + 8'd1;
                        end
                        priority if (r_byte_index == IDX_COUNT) begin
                            n_record_count = byte_val;
                        end else if (r_byte_index == IDX_ADDR_HI) begin
                            n_record_address[15:8] = byte_val;
                        end else if (r_byte_index == IDX_ADDR_LO) begin
                            n_record_address[7:0] = byte_val;
                        end else if (r_byte_index == IDX_TYPE) begin
                            n_record_type = byte_val;
                        end else if (data_off < REC_MAX) begin
                            o_wr_en = 1'b1;
                        end else if (data_off > REC_MAX) begin
                            n_flags[FLAG_OVER] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count     <= 8'd0;
            r_pending        <= 4'd0;
            r_byte_sum       <= 8'd0;
            r_byte_index     <= 8'd0;
            r_record_count   <= 8'd0;
            r_record_address <= 16'd0;
            r_record_type    <= 8'd0;
            r_flags          <= 3'd0;
        end else begin
            r_char_count     <= n_char_count;
            r_pending        <= n_pending;
            r_byte_sum       <= n_byte_sum;
            r_byte_index     <= n_byte_index;
            r_record_count   <= n_record_count;
            r_record_address <= n_record_address;
            r_record_type    <= n_record_type;
            r_flags          <= n_flags;
        end
    end

endmodule

`default_nettype wire

### rtl/ihex_linebuf.sv
`default_nettype none

module ihex_linebuf #(
    parameter int IW = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [IW-1:0]        i_wr_index,
    input  wire logic [7:0]           i_wr_data,
    input  wire logic                 i_push,
    input  wire ihex_pkg::t_line_job  i_job,
    input  wire logic                 i_pop,
    input  wire logic [IW-1:0]        i_rd_index,
    output logic                      o_full,
    output logic                      o_job_valid,
    output ihex_pkg::t_line_job       o_job,
    output logic [7:0]                o_rd_data
);
    import ihex_pkg::*;

    localparam int DEPTH = 1 << IW;

    // Two banks: one fills with the line being decoded, the other drains.
    logic [7:0]  r_mem [2][DEPTH];
    t_line_job   r_jobs [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic [7:0]  r_rd_data;
    logic        rd_bank;

    assign o_full      = (r_count == 2'd2);
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_jobs[r_rd_ptr];
    assign o_rd_data   = r_rd_data;
    assign rd_bank     = i_pop ? ~r_rd_ptr : r_rd_ptr;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_jobs[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr][i_wr_index] <= i_wr_data;
        end
        r_rd_data <= r_mem[rd_bank][i_rd_index];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("line queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("line pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_job_valid)
        else $error("line popped from an empty queue");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> !o_full)
        else $error("data byte written while both banks are held");

endmodule

`default_nettype wire

### rtl/ihex_back.sv
`default_nettype none

module ihex_back #(
    parameter int IW = 5,
    parameter int CW = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_job_valid,
    input  wire ihex_pkg::t_line_job  i_job,
    input  wire logic [7:0]           i_rd_data,
    output logic                      o_pop,
    output logic [IW-1:0]             o_rd_index,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output ihex_pkg::t_out_item       o_out_item
);
    import ihex_pkg::*;

    logic [CW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;
    logic          can_load;
    logic          fire;
    logic          has_write;

    assign can_load  = !r_out_valid || i_out_ready;
    assign fire      = i_job_valid && can_load;
    assign has_write = i_job.do_writes && ({{(8-CW){1'b0}}, r_idx} < i_job.count);
    assign o_pop     = fire && !has_write;
    // The buffer read is registered, so it is addressed with the index the next cycle will use.
    assign o_rd_index  = n_idx[IW-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (fire) begin
            n_out_valid = 1'b1;
            if (has_write) begin
                n_idx               = CW'(r_idx + 1'b1);
                n_out.result_kind   = KIND_WRITE;
                n_out.write_address = i_job.address + 16'(r_idx);
                n_out.write_data    = i_rd_data;
                n_out.line_status   = ST_OK;
                n_out.last_of_line  = 1'b0;
            end else begin
                n_idx               = '0;
                n_out.result_kind   = KIND_STATUS;
                n_out.write_address = 16'd0;
                n_out.write_data    = 8'd0;
                n_out.line_status   = i_job.status;
                n_out.last_of_line  = 1'b1;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> ({{(8-CW){1'b0}}, r_idx} <= i_job.count))
        else $error("write index ran past the record count");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_job_valid |-> (r_idx == '0))
        else $error("write index not cleared between lines");

endmodule

`default_nettype wire

### rtl/intel_hex_record_loader_top.sv
// Intel HEX line loader.
//
// Input channel (i_in_valid / o_in_ready / i_in_item): one ASCII character of
// a record line per item, then one item with end_of_line set. Characters are
// taken one per cycle. Output channel (o_out_valid / i_out_ready / o_out_item):
// for a good data record, one memory write item per data byte at a rising
// 16-bit address, then one line status item with last_of_line set. Every line,
// empty or not, ends in exactly one status item.
// The first result of a line is offered after its end-of-line item has passed
// through the line queue and the output register; results then leave one per
// cycle while the receiver keeps up, N + 1 of them for a line with N data bytes.
// A two-entry line queue with two data banks sits between the decoder and the
// drain sequencer, so the next line is decoded while the previous one drains.
// The input stalls only when two finished lines are still waiting to drain.
// When the receiver stalls, the result is held in the output register and
// draining pauses; decoding goes on until the queue fills.
// Reset (synchronous, active low) empties the queue, drops any partial line
// and clears the output valid. Buffered data needs no clearing.
`default_nettype none

module intel_hex_record_loader_top #(
    parameter int MAX_RECORD_BYTES = 32,
    parameter int MAX_LINE_CHARS   = 254
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire ihex_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output ihex_pkg::t_out_item       o_out_item
);
    import ihex_pkg::*;

    // Buffer index width and a write counter wide enough to hold the maximum.
    localparam int IW = $clog2(MAX_RECORD_BYTES);
    localparam int CW = $clog2(MAX_RECORD_BYTES + 1);

    logic          accept;
    logic          wr_en;
    logic [IW-1:0] wr_index;
    logic [7:0]    wr_data;
    logic          push;
    t_line_job     push_job;
    logic          full;
    logic          job_valid;
    t_line_job     head_job;
    logic          pop;
    logic [IW-1:0] rd_index;
    logic [7:0]    rd_data;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    ihex_front #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
        .MAX_LINE_CHARS   (MAX_LINE_CHARS),
        .IW               (IW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .o_wr_en    (wr_en),
        .o_wr_index (wr_index),
        .o_wr_data  (wr_data),
        .o_push     (push),
        .o_job      (push_job)
    );

    ihex_linebuf #(
        .IW (IW)
    ) u_linebuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_index  (wr_index),
        .i_wr_data   (wr_data),
        .i_push      (push),
        .i_job       (push_job),
        .i_pop       (pop),
        .i_rd_index  (rd_index),
        .o_full      (full),
        .o_job_valid (job_valid),
        .o_job       (head_job),
        .o_rd_data   (rd_data)
    );

    ihex_back #(
        .IW (IW),
        .CW (CW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .i_rd_data   (rd_data),
        .o_pop       (pop),
        .o_rd_index  (rd_index),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
